// File: rtl/ascon_pkg.sv
// Package with shared types, constants and the Ascon round function.
`default_nettype none
package ascon_pkg;
    localparam int INIT_ROUNDS_DEF  = 12;
    localparam int BLOCK_ROUNDS_DEF = 8;
    localparam int RATE_BYTES_DEF   = 16;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_ASSOC = 2'd1,
        MODE_TEXT  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ASSOC = 2'd1,
        PH_TEXT  = 2'd2,
        PH_SPARE = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT_RUN,
        ST_INIT_END,
        ST_ABSORB,
        ST_ABS_RUN,
        ST_PAD,
        ST_PAD_RUN,
        ST_FLIP,
        ST_TEXT,
        ST_TEXT_RUN,
        ST_FIN,
        ST_FIN_RUN,
        ST_TAG,
        ST_DONE
    } t_state;

    // One classified command handed from the front to the back.
    typedef struct packed {
        t_mode      mode;
        logic [63:0] wu;
        logic [63:0] wl;
        logic [4:0]  n;
        logic        last;
        logic        dec;
    } t_cmd;

    typedef logic [63:0] t_lanes [5];

    function automatic logic [63:0] rotr(input logic [63:0] v, input int r);
        rotr = (v >> r) | (v << (64 - r));
    endfunction

    // One permutation round with round index i (0..11).
    function automatic logic [319:0] round_fn(input logic [319:0] s, input logic [3:0] i);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        x0 = s[319:256]; x1 = s[255:192]; x2 = s[191:128]; x3 = s[127:64]; x4 = s[63:0];
        x2 = x2 ^ {56'd0, 4'(4'd15 - i), i};
        x0 ^= x4; x4 ^= x3; x2 ^= x1;
        t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
        x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
        x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
        round_fn = {x0 ^ rotr(x0, 19) ^ rotr(x0, 28),
                    x1 ^ rotr(x1, 61) ^ rotr(x1, 39),
                    x2 ^ rotr(x2, 1) ^ rotr(x2, 6),
                    x3 ^ rotr(x3, 10) ^ rotr(x3, 17),
                    x4 ^ rotr(x4, 7) ^ rotr(x4, 41)};
    endfunction

    // Mask selecting the first n bytes (0..16) of the 128-bit block.
    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < n) m[127 - 8*b -: 8] = 8'hff;
        end
        byte_mask = m;
    endfunction

    // Pad byte 0x80 at byte position n (0..15).
    function automatic logic [127:0] pad_vec(input logic [4:0] n);
        pad_vec = {8'h80, 120'd0} >> {n[3:0], 3'b000};
    endfunction
endpackage
`default_nettype wire

// File: rtl/ascon_aead_core_unit.sv
// Top level of the Ascon-128a AEAD core: key registers, front end and back end.
//
// Usage: write key_upper (index 0) and key_lower (index 1) through the
// configuration channel, then send a begin item (mode 0) with the nonce,
// associated-data blocks (mode 1) and text blocks (mode 2). Input and output
// channels transfer on valid high and stall low. A text block with bytes returns
// one result; the last text block also returns the tag (is_tag, run_end set).
// A begin occupies the back end for dequeue, load, the initialisation rounds
// and the key mix; a full block for dequeue, load, absorb and the block rounds.
// The tag follows the finalisation rounds after the last text block. Closing
// associated data adds the padding rounds and the flip. The permutation runs
// one round per cycle; items run one at a time. Mode 3 is dropped at the front.
// A two-entry command queue lets the front accept while the back works.
// Reset clears the state, phase and keys; results stay held while the
// receiver stalls, and the back end waits when its output register is full.
`default_nettype none
module ascon_aead_core_unit #(
    parameter int INIT_ROUNDS  = ascon_pkg::INIT_ROUNDS_DEF,
    parameter int BLOCK_ROUNDS = ascon_pkg::BLOCK_ROUNDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_word_upper,
    input  wire logic [63:0] i_word_lower,
    input  wire logic [4:0]  i_byte_count,
    input  wire logic        i_final_block,
    input  wire logic        i_decrypt,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_out_upper,
    output logic [63:0]      o_out_lower,
    output logic [4:0]       o_out_count,
    output logic             o_is_tag,
    output logic             o_run_end
);
    import ascon_pkg::*;

    t_cmd        w_cmd;
    logic        w_cmd_valid, w_cmd_take;
    logic [63:0] r_key_upper, r_key_lower;

    assign o_cfg_ready = 1'b1;

    // hold the key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0; r_key_lower <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index) r_key_lower <= i_cfg_data;
            else r_key_upper <= i_cfg_data;
        end
    end

    ascon_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_word_upper, .i_word_lower,
        .i_byte_count, .i_final_block, .i_decrypt,
        .o_cmd(w_cmd), .o_cmd_valid(w_cmd_valid), .i_cmd_take(w_cmd_take)
    );

    ascon_back #(.INIT_ROUNDS(INIT_ROUNDS), .BLOCK_ROUNDS(BLOCK_ROUNDS)) u_back (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_cmd_valid(w_cmd_valid), .o_cmd_take(w_cmd_take),
        .i_key_upper(r_key_upper), .i_key_lower(r_key_lower),
        .o_valid, .i_stall, .o_out_upper, .o_out_lower, .o_out_count, .o_is_tag, .o_run_end
    );
endmodule
`default_nettype wire

// File: rtl/ascon_front.sv
// Front end: accepts items, saturates counts, drops mode 3, queues commands.
`default_nettype none
module ascon_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_word_upper,
    input  wire logic [63:0] i_word_lower,
    input  wire logic [4:0]  i_byte_count,
    input  wire logic        i_final_block,
    input  wire logic        i_decrypt,
    output ascon_pkg::t_cmd  o_cmd,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_take
);
    import ascon_pkg::*;

    t_cmd        r_q [QUEUE_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop, w_keep;
    logic [4:0]  w_n;
    t_cmd        w_cmd;

    // classify the arriving item
    always_comb begin
        w_n = (i_byte_count > 5'(RATE_BYTES_DEF)) ? 5'(RATE_BYTES_DEF) : i_byte_count;
        w_cmd.mode = t_mode'(i_mode);
        w_cmd.wu   = i_word_upper;
        w_cmd.wl   = i_word_lower;
        w_cmd.n    = w_n;
        w_cmd.last = i_final_block || (w_n < 5'(RATE_BYTES_DEF));
        w_cmd.dec  = i_decrypt;
        w_keep     = (t_mode'(i_mode) != MODE_NONE);
    end

    assign o_stall     = (r_cnt == 2'(QUEUE_DEPTH));
    assign w_push      = i_valid && !o_stall && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    // hold the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    ap_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    ap_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    ap_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QUEUE_DEPTH) |-> o_stall) else $error("full queue not stalling");
endmodule
`default_nettype wire

// File: rtl/ascon_back.sv
// Back end: sequencer with one permutation round per cycle and output register.
`default_nettype none
module ascon_back #(
    parameter int INIT_ROUNDS  = 12,
    parameter int BLOCK_ROUNDS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  ascon_pkg::t_cmd  i_cmd,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_take,
    input  wire logic [63:0] i_key_upper,
    input  wire logic [63:0] i_key_lower,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_out_upper,
    output logic [63:0]      o_out_lower,
    output logic [4:0]       o_out_count,
    output logic             o_is_tag,
    output logic             o_run_end
);
    import ascon_pkg::*;

    localparam logic [63:0] IV = {8'd128, 8'(RATE_BYTES_DEF * 8), 8'(INIT_ROUNDS),
                                  8'(BLOCK_ROUNDS), 32'd0};

    t_state       r_st, n_st;
    logic [319:0] r_s, n_s;
    logic [3:0]   r_rnd, n_rnd;
    t_phase       r_ph, n_ph;
    logic         r_dec, n_dec, r_saw, n_saw;
    t_cmd         r_c;
    logic         r_ov, n_ov;
    logic [63:0]  r_ou, r_ol, n_ou, n_ol;
    logic [4:0]   r_oc, n_oc;
    logic         r_ot, r_oe, n_ot, n_oe;
    logic [127:0] w_m, w_d, w_r, w_o;
    logic         w_last_rnd, w_out_free;

    assign w_m        = byte_mask(r_c.n);
    assign w_d        = {r_c.wu, r_c.wl} & w_m;
    assign w_r        = r_s[319:192];
    assign w_last_rnd = (r_rnd == 4'd11);
    assign w_out_free = !r_ov || !i_stall;
    assign o_cmd_take = (r_st == ST_IDLE);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:     if (i_cmd_valid) n_st = ST_LOAD;
            ST_LOAD: begin
                case (r_c.mode)
                    MODE_BEGIN: n_st = ST_INIT_RUN;
                    MODE_ASSOC: n_st = (r_ph == PH_ASSOC) ? ST_ABSORB : ST_IDLE;
                    MODE_TEXT: begin
                        if (r_ph == PH_ASSOC) n_st = r_saw ? ST_PAD : ST_FLIP;
                        else if (r_ph == PH_TEXT) n_st = ST_TEXT;
                        else n_st = ST_IDLE;
                    end
                    default:    n_st = ST_IDLE;
                endcase
            end
            ST_INIT_RUN: if (w_last_rnd) n_st = ST_INIT_END;
            ST_INIT_END: n_st = ST_IDLE;
            ST_ABSORB: begin
                if (r_c.n == 5'd16) n_st = ST_ABS_RUN;
                else if (r_c.last) n_st = (r_saw || r_c.n != 5'd0) ? ST_PAD : ST_FLIP;
                else n_st = ST_IDLE;
            end
            ST_ABS_RUN: if (w_last_rnd)
                n_st = !r_c.last ? ST_IDLE : ST_PAD;
            ST_PAD:      n_st = ST_PAD_RUN;
            ST_PAD_RUN:  if (w_last_rnd) n_st = ST_FLIP;
            ST_FLIP:     n_st = (r_c.mode == MODE_TEXT) ? ST_TEXT : ST_IDLE;
            ST_TEXT: begin
                if (r_c.n == 5'd0) n_st = ST_FIN;
                else if (w_out_free) n_st = (r_c.n == 5'd16) ? ST_TEXT_RUN : ST_FIN;
            end
            ST_TEXT_RUN: if (w_last_rnd) n_st = r_c.last ? ST_FIN : ST_IDLE;
            ST_FIN:      n_st = ST_FIN_RUN;
            ST_FIN_RUN:  if (w_last_rnd) n_st = ST_TAG;
            ST_TAG:      if (w_out_free) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_s = r_s; n_rnd = r_rnd + 4'd1; n_ph = r_ph; n_dec = r_dec; n_saw = r_saw;
        n_ov = r_ov && i_stall;
        n_ou = r_ou; n_ol = r_ol; n_oc = r_oc; n_ot = r_ot; n_oe = r_oe;
        w_o = '0;
        case (r_st)
            ST_LOAD: begin
                if (r_c.mode == MODE_BEGIN) begin
                    n_s = {IV, i_key_upper, i_key_lower, r_c.wu, r_c.wl};
                    n_rnd = 4'(12 - INIT_ROUNDS);
                end
            end
            ST_INIT_RUN: n_s = round_fn(r_s, r_rnd);
            ST_INIT_END: begin
                n_s[127:0] = r_s[127:0] ^ {i_key_upper, i_key_lower};
                n_dec = r_c.dec; n_saw = 1'b0; n_ph = PH_ASSOC;
            end
            ST_ABSORB: begin
                n_s[319:192] = w_r ^ w_d;
                if (r_c.n != 5'd0) n_saw = 1'b1;
                // pad a short block only when some associated data was absorbed
                if (r_c.n != 5'd16 && (r_saw || r_c.n != 5'd0))
                    n_s[319:192] = w_r ^ w_d ^ pad_vec(r_c.n);
                n_rnd = 4'(12 - BLOCK_ROUNDS);
            end
            ST_ABS_RUN: begin
                n_s = round_fn(r_s, r_rnd);
                if (w_last_rnd && r_c.last) n_s[319:192] = n_s[319:192] ^ pad_vec(5'd0);
            end
            ST_PAD: begin
                // first call from text: pad-only block; short assoc already padded
                if (r_c.mode == MODE_TEXT) n_s[319:192] = w_r ^ pad_vec(5'd0);
                n_rnd = 4'(12 - BLOCK_ROUNDS) + 4'd1;
                n_s = round_fn(r_c.mode == MODE_TEXT ?
                               {w_r ^ pad_vec(5'd0), r_s[191:0]} : r_s,
                               4'(12 - BLOCK_ROUNDS));
            end
            ST_PAD_RUN: n_s = round_fn(r_s, r_rnd);
            ST_FLIP: begin
                n_s[0] = !r_s[0];
                n_ph = PH_TEXT;
            end
            ST_TEXT: begin
                if (r_c.n != 5'd0 && w_out_free) begin
                    if (r_dec) begin
                        w_o = (w_r ^ w_d) & w_m;
                        n_s[319:192] = (w_r & ~w_m) | w_d;
                    end else begin
                        w_o = (w_r ^ w_d) & w_m;
                        n_s[319:192] = w_r ^ w_d;
                    end
                    if (r_c.n != 5'd16) n_s[319:192] = n_s[319:192] ^ pad_vec(r_c.n);
                    n_ov = 1'b1; n_ou = w_o[127:64]; n_ol = w_o[63:0];
                    n_oc = r_c.n; n_ot = 1'b0; n_oe = !r_c.last;
                end
                n_rnd = 4'(12 - BLOCK_ROUNDS);
            end
            ST_TEXT_RUN: begin
                n_s = round_fn(r_s, r_rnd);
                if (w_last_rnd && r_c.last) n_s[319:192] = n_s[319:192] ^ pad_vec(5'd0);
            end
            ST_FIN: begin
                if (r_c.n == 5'd0) n_s[319:192] = w_r ^ pad_vec(5'd0);
                n_s[191:64] = r_s[191:64] ^ {i_key_upper, i_key_lower};
                n_rnd = 4'(12 - INIT_ROUNDS);
            end
            ST_FIN_RUN: n_s = round_fn(r_s, r_rnd);
            ST_TAG: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_ou = r_s[127:64] ^ i_key_upper;
                    n_ol = r_s[63:0] ^ i_key_lower;
                    n_oc = 5'd16; n_ot = 1'b1; n_oe = 1'b1;
                    n_ph = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ph <= PH_IDLE; r_dec <= 1'b0; r_saw <= 1'b0;
            r_ov <= 1'b0; r_s <= '0; r_rnd <= 4'd0;
        end else begin
            r_st <= n_st; r_ph <= n_ph; r_dec <= n_dec; r_saw <= n_saw;
            r_ov <= n_ov; r_s <= n_s; r_rnd <= n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_cmd_valid) r_c <= i_cmd;
        r_ou <= n_ou; r_ol <= n_ol; r_oc <= n_oc; r_ot <= n_ot; r_oe <= n_oe;
    end

    assign o_valid     = r_ov;
    assign o_out_upper = r_ou;
    assign o_out_lower = r_ol;
    assign o_out_count = r_oc;
    assign o_is_tag    = r_ot;
    assign o_run_end   = r_oe;

    ap_tag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_tag |-> o_out_count == 5'd16 && o_run_end)
        else $error("tag result malformed");
    ap_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_st == ST_IDLE) else $error("command taken while busy");
    ap_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_INIT_RUN || r_st == ST_FIN_RUN) |-> r_rnd <= 4'd11)
        else $error("round counter out of range");
endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the Ascon-128a AEAD core unit.
`timescale 1ns / 100ps
`default_nettype none

class ascon_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [63:0] st [5];
    ascon_pkg::t_phase ph;
    bit dec_mode, absorbed;
    logic [134:0] pending [$];
    int errors;

    function new();
        key_hi = '0; key_lo = '0;
        foreach (st[i]) st[i] = '0;
        ph = ascon_pkg::PH_IDLE; dec_mode = 0; absorbed = 0; errors = 0;
    endfunction

    function automatic logic [63:0] ror(logic [63:0] v, int r);
        return (v >> r) | (v << (64 - r));
    endfunction

    function void rounds(int cnt);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        for (int i = 12 - cnt; i < 12; i++) begin
            x0 = st[0]; x1 = st[1]; x2 = st[2]; x3 = st[3]; x4 = st[4];
            x2 ^= 64'(((15 - i) << 4) | i);
            x0 ^= x4; x4 ^= x3; x2 ^= x1;
            t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
            x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
            x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
            st[0] = x0 ^ ror(x0, 19) ^ ror(x0, 28);
            st[1] = x1 ^ ror(x1, 61) ^ ror(x1, 39);
            st[2] = x2 ^ ror(x2, 1) ^ ror(x2, 6);
            st[3] = x3 ^ ror(x3, 10) ^ ror(x3, 17);
            st[4] = x4 ^ ror(x4, 7) ^ ror(x4, 41);
        end
    endfunction

    function void pad(int n);
        logic [127:0] p;
        p = {8'h80, 120'd0} >> (8 * n);
        st[0] ^= p[127:64]; st[1] ^= p[63:0];
    endfunction

    function void set_key(bit idx, logic [63:0] v);
        if (idx == 1'b0) key_hi = v; else key_lo = v;
    endfunction

    // Predict the results of one accepted input transfer
    function void note_input(logic [1:0] mode, logic [63:0] wu, logic [63:0] wl,
                             logic [4:0] cnt, bit fin, bit dec);
        int n;
        bit last;
        logic [127:0] m;
        logic [63:0] mu, ml, du, dl, ou, ol;
        n = (cnt > 16) ? 16 : cnt;
        last = fin || n < 16;
        m = '0;
        for (int b = 0; b < n; b++) m[127 - 8*b -: 8] = 8'hff;
        mu = m[127:64]; ml = m[63:0];
        du = wu & mu; dl = wl & ml;
        case (mode)
            ascon_pkg::MODE_BEGIN: begin
                st[0] = 64'h80800c08_00000000;
                st[1] = key_hi; st[2] = key_lo; st[3] = wu; st[4] = wl;
                rounds(12);
                st[3] ^= key_hi; st[4] ^= key_lo;
                dec_mode = dec; absorbed = 0; ph = ascon_pkg::PH_ASSOC;
            end
            ascon_pkg::MODE_ASSOC: begin
                if (ph == ascon_pkg::PH_ASSOC) begin
                    if (n > 0) begin
                        st[0] ^= du; st[1] ^= dl; absorbed = 1;
                        if (n == 16) rounds(8);
                    end
                    if (last) begin
                        if (absorbed) begin pad(n < 16 ? n : 0); rounds(8); end
                        st[4] ^= 64'd1; ph = ascon_pkg::PH_TEXT;
                    end
                end
            end
            ascon_pkg::MODE_TEXT: begin
                if (ph == ascon_pkg::PH_ASSOC) begin
                    if (absorbed) begin pad(0); rounds(8); end
                    st[4] ^= 64'd1; ph = ascon_pkg::PH_TEXT;
                end
                if (ph == ascon_pkg::PH_TEXT) begin
                    if (n > 0) begin
                        if (dec_mode) begin
                            ou = (st[0] ^ du) & mu; ol = (st[1] ^ dl) & ml;
                            st[0] = (st[0] & ~mu) | du; st[1] = (st[1] & ~ml) | dl;
                        end else begin
                            st[0] ^= du; st[1] ^= dl;
                            ou = st[0] & mu; ol = st[1] & ml;
                        end
                        pending.push_back({ou, ol, 5'(n), 1'b0, !last});
                        if (n == 16) rounds(8);
                    end
                    if (last) begin
                        pad(n < 16 ? n : 0);
                        st[2] ^= key_hi; st[3] ^= key_lo;
                        rounds(12);
                        st[3] ^= key_hi; st[4] ^= key_lo;
                        pending.push_back({st[3], st[4], 5'd16, 1'b1, 1'b1});
                        ph = ascon_pkg::PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Compare one result transfer against the oldest prediction
    task check_result(logic [63:0] u, logic [63:0] l, logic [4:0] c,
                      bit tag, bit fin);
        logic [134:0] e;
        if (pending.size() == 0) begin
            report("unexpected result", u, '0);
            return;
        end
        e = pending.pop_front();
        if (u != e[134:71]) report("out_upper", u, e[134:71]);
        if (l != e[70:7]) report("out_lower", l, e[70:7]);
        if (c != e[6:2]) report("out_count", 64'(c), 64'(e[6:2]));
        if (tag != e[1]) report("is_tag", 64'(tag), 64'(e[1]));
        if (fin != e[0]) report("run_end", 64'(fin), 64'(e[0]));
    endtask
endclass

module tb;
    import ascon_pkg::*;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_valid = 0, i_cfg_index = 0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 0, i_final_block = 0, i_decrypt = 0, i_stall = 0;
    logic [1:0]  i_mode = MODE_NONE;
    logic [63:0] i_word_upper = '0, i_word_lower = '0;
    logic [4:0]  i_byte_count = '0;
    wire         o_cfg_ready, o_stall, o_valid, o_is_tag, o_run_end;
    wire  [63:0] o_out_upper, o_out_lower;
    wire  [4:0]  o_out_count;

    ascon_scoreboard sb = new();
    int unsigned cycles = 0;
    bit rx_quiet = 0;

    ascon_aead_core_unit u_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("[ascon_aead_core_unit] ERROR");
            $finish;
        end
    end

    // Check results and draw receiver stalls
    initial begin : receiver
        int gap;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                sb.check_result(o_out_upper, o_out_lower, o_out_count, o_is_tag, o_run_end);
            if (i_stall) begin
                if (gap > 0) gap--; else i_stall <= 0;
            end else if (o_valid && !rx_quiet) begin
                gap = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) gap = 0;
                if (gap > 0) i_stall <= 1;
            end
        end
    end

    task automatic write_key(bit idx, logic [63:0] v);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_key(idx, v);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // Valid stays high after a transfer when the next item follows at once
    task automatic send(logic [1:0] mode, logic [63:0] wu, logic [63:0] wl,
                        logic [4:0] cnt, bit fin, bit dec, bit nogap = 1'b0);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1; i_mode <= mode; i_word_upper <= wu; i_word_lower <= wl;
        i_byte_count <= cnt; i_final_block <= fin; i_decrypt <= dec;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(mode, wu, wl, cnt, fin, dec);
    endtask

    // Wait until every prediction has been met, then let the core settle
    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic message(bit burst, output int sent);
        int na, nt;
        bit dec;
        dec = 1'($urandom_range(0, 1));
        send(MODE_BEGIN, rnd64(), rnd64(), 5'($urandom), 1'($urandom), dec, burst);
        na = $urandom_range(0, 3);
        for (int i = 0; i < na; i++)
            send(MODE_ASSOC, rnd64(), rnd64(),
                 (i == na - 1) ? 5'($urandom_range(0, 16)) : 5'd16,
                 i == na - 1, 1'($urandom), burst);
        nt = $urandom_range(1, 4);
        for (int i = 0; i < nt; i++)
            send(MODE_TEXT, rnd64(), rnd64(),
                 (i == nt - 1) ? 5'($urandom_range(0, 31)) : 5'd16,
                 i == nt - 1, 1'($urandom), burst);
        sent = 1 + na + nt;
    endtask

    initial begin : stimulus
        int items;
        int sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_key(1'b0, '0);
        write_key(1'b1, '0);
        // Directed: zero key, empty associated data, empty last text
        send(MODE_BEGIN, '0, '0, 5'd0, 1'b0, 1'b0);
        send(MODE_TEXT, '0, '0, 5'd0, 1'b1, 1'b0);
        // Ignored items in idle
        send(MODE_ASSOC, '1, '1, 5'd16, 1'b1, 1'b1);
        send(MODE_TEXT, '1, '1, 5'd16, 1'b1, 1'b1);
        send(MODE_NONE, '1, '1, 5'd16, 1'b1, 1'b1);
        drain();
        write_key(1'b0, '1);
        write_key(1'b1, '1);
        // Full last assoc block, oversized count, full last text block
        send(MODE_BEGIN, '1, '1, 5'd31, 1'b1, 1'b1);
        send(MODE_ASSOC, '1, '1, 5'd16, 1'b1, 1'b0);
        send(MODE_TEXT, '1, '1, 5'd31, 1'b1, 1'b0);
        // Short assoc block, then ignored assoc in text phase, short text
        send(MODE_BEGIN, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0, 1'b0, 1'b0);
        send(MODE_ASSOC, '1, '1, 5'd5, 1'b0, 1'b0);
        send(MODE_ASSOC, '1, '1, 5'd16, 1'b1, 1'b0);
        send(MODE_TEXT, rnd64(), rnd64(), 5'd16, 1'b0, 1'b0);
        send(MODE_TEXT, rnd64(), rnd64(), 5'd9, 1'b0, 1'b0);
        // Text closes open associated data; decrypt
        send(MODE_BEGIN, rnd64(), rnd64(), 5'd0, 1'b0, 1'b1);
        send(MODE_ASSOC, rnd64(), rnd64(), 5'd16, 1'b0, 1'b0);
        send(MODE_TEXT, rnd64(), rnd64(), 5'd8, 1'b1, 1'b0);
        // Begin restarts mid-message; assoc with zero bytes and final
        send(MODE_BEGIN, rnd64(), rnd64(), 5'd0, 1'b0, 1'b1);
        send(MODE_ASSOC, rnd64(), rnd64(), 5'd0, 1'b1, 1'b0);
        send(MODE_BEGIN, rnd64(), rnd64(), 5'd0, 1'b0, 1'b0);
        send(MODE_TEXT, rnd64(), rnd64(), 5'd1, 1'b1, 1'b0);
        drain();
        // Random messages over several keys, with hold-off between phases
        items = 0;
        while (items < 750) begin
            if (items % 150 == 0) begin
                drain();
                write_key(1'b0, rnd64());
                write_key(1'b1, rnd64());
                rx_quiet = (items == 300);
            end
            if ($urandom_range(0, 9) == 0) begin
                send(2'($urandom), rnd64(), rnd64(), 5'($urandom), 1'($urandom),
                     1'($urandom));
                items++;
            end else begin
                message(items >= 300 && items < 360, sent);
                items += sent;
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ascon_aead_core_unit] OK");
        else
            $display("[ascon_aead_core_unit] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
